FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CIM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the next cycle
`define CIM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/cim_pkg.sv
// shared types and codes for the callback integrity monitor
`default_nettype none
package cim_pkg;
    localparam logic [3:0] ST_NULL      = 4'd0;
    localparam logic [3:0] ST_REGISTER  = 4'd1;
    localparam logic [3:0] ST_MATCH     = 4'd2;
    localparam logic [3:0] ST_MISMATCH  = 4'd3;
    localparam logic [3:0] ST_BLOCKED   = 4'd4;
    localparam logic [3:0] ST_FULL      = 4'd5;
    localparam logic [3:0] ST_RET_OK    = 4'd6;
    localparam logic [3:0] ST_RET_BAD   = 4'd7;
    localparam logic [3:0] ST_EMPTY     = 4'd8;

    localparam logic [1:0] REG_CHECKING = 2'd0;
    localparam logic [1:0] REG_STRICT   = 2'd1;
    localparam logic [1:0] REG_STACK    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

FILE: rtl/cim_stack.sv
// shadow stack memory: one write port, one registered read port
`default_nettype none
module cim_stack #(
    parameter int DEPTH = 64,
    parameter int AW    = 48
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [2*AW-1:0]          wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [2*AW-1:0]          rdata
);
    logic [2*AW-1:0] mem [DEPTH];

    // write then registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/cim_table.sv
// hash registry: key/hash memory rows and per-entry flags and counters
`default_nettype none
module cim_table #(
    parameter int ENTRIES = 16,
    parameter int AW      = 48
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [AW-1:0]              key,
    // row write
    input  wire logic                       we,
    input  wire logic [$clog2(ENTRIES)-1:0] waddr,
    input  wire logic                       wkey,
    input  wire logic                       whash_en,
    input  wire logic [63:0]                whash,
    input  wire logic [7:0]                 wcount,
    // lookup results, registered
    output logic                            found,
    output logic [$clog2(ENTRIES)-1:0]      found_idx,
    output logic                            has_free,
    output logic [$clog2(ENTRIES)-1:0]      free_idx,
    output logic [63:0]                     found_hash,
    output logic [7:0]                      found_count
);
    localparam int IW = $clog2(ENTRIES);

    logic [AW-1:0] key_mem   [ENTRIES];
    logic [63:0]   hash_mem  [ENTRIES];
    logic [7:0]    count_reg [ENTRIES];
    logic [ENTRIES-1:0] used_reg;
    logic          hit;
    logic [IW-1:0] hit_idx;
    logic          fre;
    logic [IW-1:0] fre_idx;

    // key match and first free entry, lowest index wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        fre     = 1'b0;
        fre_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (used_reg[i] && key_mem[i] == key) begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
            if (!used_reg[i]) begin
                fre     = 1'b1;
                fre_idx = IW'(i);
            end
        end
    end

    // flags and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                count_reg[i] <= '0;
            end
        end else if (we) begin
            used_reg[waddr]  <= 1'b1;
            count_reg[waddr] <= wcount;
        end
    end

    // row storage and registered lookup
    always_ff @(posedge aclk) begin
        if (we) begin
            if (whash_en) begin
                hash_mem[waddr] <= whash;
            end
            if (wkey) begin
                key_mem[waddr] <= key;
            end
        end
        found       <= hit;
        found_idx   <= hit_idx;
        has_free    <= fre;
        free_idx    <= fre_idx;
        found_hash  <= hash_mem[hit_idx];
        found_count <= count_reg[hit_idx];
    end
endmodule
`default_nettype wire

FILE: rtl/callback_integrity_monitor_top.sv
// callback integrity monitor: shadow stack plus hash registry
//
// Input beats (s_valid/s_ready) carry a call or a return with object address,
// return address and object hash. Each beat gives exactly one result beat on
// m_valid/m_ready. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); the user must write it only while the block is idle, as the
// block itself does not enforce this. An item passes through S_IDLE, S_LOOK
// and S_DONE: the accept edge loads it and pushes a call, the next edge
// registers the table lookup and stack read data, and the result register
// is loaded on leaving S_DONE. S_LOOK waits for the registered table and
// stack memory reads. The result stays in the output register until taken;
// a new item is not accepted until the result register is free.
// Reset (synchronous, aresetn low) clears the used flags, violation
// counters, stack pointer and totals, and sets checking and the shadow
// stack on, strict mode off. No clearing pass is needed.
`default_nettype none
module callback_integrity_monitor_top
    import cim_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int STACK_DEPTH   = 64,
    parameter int ADDR_BITS     = 48
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic                  cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_action,
    input  wire logic [ADDR_BITS-1:0]  s_object_address,
    input  wire logic [ADDR_BITS-1:0]  s_return_address,
    input  wire logic [63:0]           s_object_hash,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_allow,
    output logic                       m_abort_request,
    output logic [3:0]                 m_status,
    output logic                       m_stack_overflow,
    output logic [7:0]                 m_entry_violations,
    output logic [31:0]                m_total_violations,
    output logic [6:0]                 m_stack_depth
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    state_t state_reg, state_next;
    logic chk_reg, strict_reg, stk_reg;
    logic [PW-1:0] sp_reg, sp_next;
    logic [31:0] vtot_reg, vtot_next;
    logic act_reg;
    logic [ADDR_BITS-1:0] obj_reg, ret_reg;
    logic [63:0] hash_reg;
    logic ovf_reg, push_reg;
    logic out_v_reg;
    logic o_allow, o_abort, o_ovf;
    logic [3:0] o_status;
    logic [7:0] o_ev;

    logic t_found, t_free;
    logic [IW-1:0] t_fidx, t_free_idx;
    logic [63:0] t_hash;
    logic [7:0] t_count;
    logic t_we, t_wkey, t_whash;
    logic [IW-1:0] t_waddr;
    logic [7:0] t_wcount;
    logic [2*ADDR_BITS-1:0] s_rdata;
    logic s_we;
    logic [SW-1:0] s_raddr;
    logic [7:0] cnt_inc;

    assign s_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign s_raddr = SW'(sp_reg - PW'(1));

    // push on acceptance of a non-null call while the shadow stack is on and not full
    assign s_we = s_valid && s_ready && !s_action && (s_object_address != '0)
                  && stk_reg && (sp_reg < PW'(STACK_DEPTH));

    cim_stack #(.DEPTH(STACK_DEPTH), .AW(ADDR_BITS)) u_stack (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (sp_reg[SW-1:0]),
        .wdata ({s_return_address, s_object_address}),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    cim_table #(.ENTRIES(TABLE_ENTRIES), .AW(ADDR_BITS)) u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .key         (obj_reg),
        .we          (t_we),
        .waddr       (t_waddr),
        .wkey        (t_wkey),
        .whash_en    (t_whash),
        .whash       (hash_reg),
        .wcount      (t_wcount),
        .found       (t_found),
        .found_idx   (t_fidx),
        .has_free    (t_free),
        .free_idx    (t_free_idx),
        .found_hash  (t_hash),
        .found_count (t_count)
    );

    assign cnt_inc = (t_count == 8'hFF) ? t_count : t_count + 8'd1;

    // state, config, stack pointer, total and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            chk_reg    <= 1'b1;
            strict_reg <= 1'b0;
            stk_reg    <= 1'b1;
            sp_reg     <= '0;
            vtot_reg   <= '0;
            out_v_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            vtot_reg  <= vtot_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHECKING: chk_reg    <= cfg_data;
                    REG_STRICT:   strict_reg <= cfg_data;
                    REG_STACK:    stk_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_DONE) begin
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // item capture, with push and overflow outcome of a call
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg  <= s_action;
            obj_reg  <= s_object_address;
            ret_reg  <= s_return_address;
            hash_reg <= s_object_hash;
            push_reg <= s_we;
            ovf_reg  <= !s_action && (s_object_address != '0) && stk_reg
                        && (sp_reg == PW'(STACK_DEPTH));
        end
    end

    // sequencer, decision and write-back
    always_comb begin
        state_next = state_reg;
        sp_next    = sp_reg;
        vtot_next  = vtot_reg;
        t_we       = 1'b0;
        t_wkey     = 1'b0;
        t_whash    = 1'b0;
        t_waddr    = t_fidx;
        t_wcount   = 8'd0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = S_LOOK;
                    if (s_we) begin
                        sp_next = sp_reg + PW'(1);
                    end
                end
            end
            S_LOOK: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                state_next = S_IDLE;
                if (obj_reg == '0) begin
                    // nothing
                end else if (act_reg) begin
                    if (stk_reg && sp_reg != '0) begin
                        sp_next = sp_reg - PW'(1);
                        if (s_rdata != {ret_reg, obj_reg}) begin
                            vtot_next = (vtot_reg == '1) ? vtot_reg : vtot_reg + 32'd1;
                        end
                    end
                end else if (chk_reg) begin
                    if (!t_found) begin
                        if (t_free) begin
                            t_we    = 1'b1;
                            t_wkey  = 1'b1;
                            t_whash = 1'b1;
                            t_waddr = t_free_idx;
                        end
                    end else if (t_hash != hash_reg) begin
                        vtot_next = (vtot_reg == '1) ? vtot_reg : vtot_reg + 32'd1;
                        // count rises, saturating at 255, hash kept in strict mode
                        t_we      = 1'b1;
                        t_whash   = !strict_reg;
                        t_wcount  = cnt_inc;
                        // blocked call withdraws its own push
                        if (strict_reg && push_reg) begin
                            sp_next = sp_reg - PW'(1);
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result fields
    always_comb begin
        o_allow  = 1'b1;
        o_abort  = 1'b0;
        o_status = ST_NULL;
        o_ev     = 8'd0;
        o_ovf    = ovf_reg;
        if (obj_reg == '0) begin
            o_ovf = 1'b0;
        end else if (act_reg) begin
            if (!stk_reg || sp_reg == '0) begin
                o_status = ST_EMPTY;
            end else if (s_rdata == {ret_reg, obj_reg}) begin
                o_status = ST_RET_OK;
            end else begin
                o_status = ST_RET_BAD;
                o_allow  = !strict_reg;
                o_abort  = strict_reg;
            end
        end else if (!chk_reg) begin
            o_status = ST_MATCH;
        end else if (!t_found) begin
            o_status = t_free ? ST_REGISTER : ST_FULL;
        end else if (t_hash == hash_reg) begin
            o_status = ST_MATCH;
            o_ev     = t_count;
        end else begin
            o_ev     = cnt_inc;
            o_status = strict_reg ? ST_BLOCKED : ST_MISMATCH;
            o_allow  = !strict_reg;
            o_abort  = strict_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE) begin
            m_allow            <= o_allow;
            m_abort_request    <= o_abort;
            m_status           <= o_status;
            m_stack_overflow   <= o_ovf;
            m_entry_violations <= o_ev;
            m_total_violations <= vtot_next;
            m_stack_depth      <= 7'(sp_next);
        end
    end

    assign m_valid = out_v_reg;
endmodule
`default_nettype wire

FILE: rtl/cim_checker.sv
// port-level checker for the callback integrity monitor, bound to the top
`default_nettype none
`include "assert_macros.svh"
module cim_checker
    import cim_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_allow,
    input wire logic        m_abort_request,
    input wire logic [3:0]  m_status,
    input wire logic [31:0] m_total_violations
);
    `CIM_ASSERT_IMP(a_abort_blocks, aclk, aresetn, m_valid && m_abort_request, !m_allow, "abort with allow")
    `CIM_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid && !m_ready, !s_ready, "accept during stall")
    `CIM_ASSERT_IMP(a_status_range, aclk, aresetn, m_valid, m_status <= ST_EMPTY, "bad status")
    `CIM_ASSERT_NEXT(a_total_mono, aclk, aresetn, m_valid && m_ready, m_total_violations >= $past(m_total_violations), "total fell")
endmodule

bind callback_integrity_monitor_top cim_checker u_cim_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_allow            (m_allow),
    .m_abort_request    (m_abort_request),
    .m_status           (m_status),
    .m_total_violations (m_total_violations)
);
`default_nettype wire
